// ----- rtl/core/htt_pkg.sv -----
// Shared types and constants of the hashed tile table.
package htt_pkg;

    localparam int HASH_W         = 16;
    localparam int NUM_HASH       = 4;
    localparam int IDX_W          = 2;
    localparam int ROW_BITS       = 16;
    localparam int ROWS           = 2 ** ROW_BITS;
    localparam int ROW_W          = 32;
    localparam int TILE_ADDR_BITS = 3;
    localparam int TILE_BITS      = 4;
    localparam int TILES          = 2 ** TILE_ADDR_BITS;
    localparam int CODE_W         = NUM_HASH - 1;
    localparam int ID_W           = 64;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_UPDATE,
        S_PRESENT
    } state_t;

    typedef struct packed {
        logic load;
        logic clear_we;
        logic rd_en;
        logic update;
        logic advance;
    } htt_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_read;
        logic last_hash;
    } htt_status_t;

endpackage

// ----- rtl/core/htt_datapath.sv -----
// Datapath: captured beat, hash index, tile table memory and tile update.
module htt_datapath
    import htt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  htt_cmd_t               cmd,
    output htt_status_t            status,
    input  logic                   opcode,
    input  logic [HASH_W-1:0]      hash_0,
    input  logic [HASH_W-1:0]      hash_1,
    input  logic [HASH_W-1:0]      hash_2,
    input  logic [HASH_W-1:0]      hash_3,
    input  logic [ID_W-1:0]        id_hash_a,
    input  logic [ID_W-1:0]        id_hash_b,
    output logic [IDX_W-1:0]       hash_index,
    output logic [ROW_W-1:0]       row_word,
    output logic                   last
);

    logic [ROW_W-1:0]          mem [ROWS];
    logic [ROW_W-1:0]          rdata_reg;
    logic [HASH_W-1:0]         h_reg [NUM_HASH];
    logic [ID_W-1:0]           ida_reg;
    logic [ID_W-1:0]           idb_reg;
    logic                      op_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    logic [ROW_BITS-1:0]       clr_addr_reg;
    logic [ROW_BITS-1:0]       clr_addr_next;

    logic [CODE_W-1:0]         code;
    logic [TILE_ADDR_BITS-1:0] col;
    logic [TILE_BITS-1:0]      val;
    logic [4:0]                shift;
    logic [ROW_W-1:0]          tile_mask;
    logic [ROW_W-1:0]          new_word;
    logic                      tile_zero;
    logic [ROW_BITS-1:0]       row;
    logic [ROW_BITS-1:0]       addr;
    logic                      we;
    logic [ROW_W-1:0]          wdata;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            h_reg[0] <= hash_0;
            h_reg[1] <= hash_1;
            h_reg[2] <= hash_2;
            h_reg[3] <= hash_3;
            ida_reg  <= id_hash_a;
            idb_reg  <= id_hash_b;
            op_reg   <= opcode;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.advance)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    assign clr_addr_next = cmd.clear_we ? clr_addr_reg + ROW_BITS'(1) : clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            idx_reg      <= idx_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        code = '0;
        for (int j = 0; j < NUM_HASH; j++)
        begin
            if (IDX_W'(j) != idx_reg)
            begin
                code = {code[CODE_W-2:0], h_reg[j][idx_reg]};
            end
        end
    end

    assign col       = ida_reg[int'(code) * TILE_ADDR_BITS +: TILE_ADDR_BITS];
    assign val       = idb_reg[int'(code) * TILE_BITS +: TILE_BITS];
    assign shift     = 5'((TILES - 1 - int'(col)) * TILE_BITS);
    assign tile_mask = {{(ROW_W - TILE_BITS){1'b0}}, {TILE_BITS{1'b1}}} << shift;
    assign tile_zero = (rdata_reg & tile_mask) == '0;
    assign new_word  = (rdata_reg & ~tile_mask)
                     | ({{(ROW_W - TILE_BITS){1'b0}}, val} << shift);

    assign row   = h_reg[idx_reg][ROW_BITS-1:0];
    assign addr  = cmd.clear_we ? clr_addr_reg : row;
    assign we    = cmd.clear_we || (cmd.update && tile_zero);
    assign wdata = cmd.clear_we ? '0 : new_word;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign status.clear_done = (clr_addr_reg == ROW_BITS'(ROWS - 1));
    assign status.is_read    = (op_reg == OP_READ);
    assign status.last_hash  = (idx_reg == IDX_W'(NUM_HASH - 1));

    assign hash_index = idx_reg;
    assign row_word   = rdata_reg;
    assign last       = status.last_hash;

endmodule

// ----- rtl/core/htt_ctrl.sv -----
// Controller state machine: clearing pass, per-hash read-modify-write and read results.
module htt_ctrl
    import htt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  htt_status_t status,
    output htt_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = status.is_read ? S_PRESENT : S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = status.last_hash ? S_IDLE : S_ISSUE;
            end
            S_PRESENT:
            begin
                if (out_ready)
                begin
                    state_next = status.last_hash ? S_IDLE : S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_we = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_ISSUE:
            begin
                cmd.rd_en = 1'b1;
            end
            S_UPDATE:
            begin
                cmd.update  = 1'b1;
                cmd.advance = !status.last_hash;
            end
            S_PRESENT:
            begin
                out_valid   = 1'b1;
                cmd.advance = out_ready && !status.last_hash;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A new beat is only taken when no result is pending.
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output active together");

    // The final row word of a read returns the block to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRESENT && out_ready && status.last_hash) |=> in_ready)
        else $error("block not idle after last row word");

    // Every tile update follows the memory read of its row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> ($past(state_reg) == S_ISSUE))
        else $error("update without preceding row read");

    // An accepted beat always starts with a row read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_ISSUE))
        else $error("accepted beat did not start a row read");

endmodule

// ----- rtl/core/hashed_tile_table_insert_read.sv -----
// Top level of the hashed tile table with insert and read.
// After reset a clearing pass zeroes all 65536 rows, one row per cycle; no beat is taken meanwhile.
// An insert does a row read (S_ISSUE) and then a conditional write (S_UPDATE) per hash on the
// single-port table; no new beat is taken until the last hash is done.
// A read reads one row word per hash in S_ISSUE and presents it in S_PRESENT until it is taken;
// no new beat is taken until the last row word is taken.
module hashed_tile_table_insert_read
    import htt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic [HASH_W-1:0]   hash_0,
    input  logic [HASH_W-1:0]   hash_1,
    input  logic [HASH_W-1:0]   hash_2,
    input  logic [HASH_W-1:0]   hash_3,
    input  logic [ID_W-1:0]     id_hash_a,
    input  logic [ID_W-1:0]     id_hash_b,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_W-1:0]    hash_index,
    output logic [ROW_W-1:0]    row_word,
    output logic                last
);

    htt_cmd_t    cmd;
    htt_status_t status;

    htt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    htt_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .opcode     (opcode),
        .hash_0     (hash_0),
        .hash_1     (hash_1),
        .hash_2     (hash_2),
        .hash_3     (hash_3),
        .id_hash_a  (id_hash_a),
        .id_hash_b  (id_hash_b),
        .hash_index (hash_index),
        .row_word   (row_word),
        .last       (last)
    );

endmodule

// ----- verif/hashed_tile_table_insert_read_tb.sv -----
// Testbench for the hashed tile table: predicts row words on reads and checks every output beat.
`timescale 1ns / 100ps

module hashed_tile_table_insert_read_tb
    import htt_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int LONG_HOLD      = 90;
    localparam int HOLD_AT_BEAT   = 45;
    localparam int QUIET_TAIL     = 20;
    localparam int RANDOM_ITEMS   = 82;
    localparam int HOT_ROWS       = 12;

    typedef struct {
        op_t                          op;
        logic [NUM_HASH-1:0][HASH_W-1:0] hashes;
        logic [ID_W-1:0]              ida;
        logic [ID_W-1:0]              idb;
        bit                           wait_drain;
    } tile_cmd_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [ROW_W-1:0] word;
        logic             last;
    } row_beat_t;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic              opcode     = 1'b0;
    logic [HASH_W-1:0] hash_0     = '0;
    logic [HASH_W-1:0] hash_1     = '0;
    logic [HASH_W-1:0] hash_2     = '0;
    logic [HASH_W-1:0] hash_3     = '0;
    logic [ID_W-1:0]   id_hash_a  = '0;
    logic [ID_W-1:0]   id_hash_b  = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [IDX_W-1:0]  hash_index;
    logic [ROW_W-1:0]  row_word;
    logic              last;

    bit [ROW_W-1:0] tile_rows [ROWS];
    tile_cmd_t      cmd_q [$];
    row_beat_t      row_words_due [$];
    int             error_count = 0;
    int             beats_in    = 0;
    int             idle_cycles = 0;
    int             tx_gap      = 0;
    int             rx_gap      = 0;
    int             hold_left   = 0;
    bit             hold_done   = 1'b0;
    logic [HASH_W-1:0] hot_row [HOT_ROWS];

    hashed_tile_table_insert_read uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .hash_0     (hash_0),
        .hash_1     (hash_1),
        .hash_2     (hash_2),
        .hash_3     (hash_3),
        .id_hash_a  (id_hash_a),
        .id_hash_b  (id_hash_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_index (hash_index),
        .row_word   (row_word),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(string what, logic [ROW_W-1:0] got, logic [ROW_W-1:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic push_cmd(op_t op, logic [HASH_W-1:0] h0, logic [HASH_W-1:0] h1,
                            logic [HASH_W-1:0] h2, logic [HASH_W-1:0] h3,
                            logic [ID_W-1:0] ida, logic [ID_W-1:0] idb, bit drain);
        tile_cmd_t c;
        c.op         = op;
        c.hashes[0]  = h0;
        c.hashes[1]  = h1;
        c.hashes[2]  = h2;
        c.hashes[3]  = h3;
        c.ida        = ida;
        c.idb        = idb;
        c.wait_drain = drain;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    function automatic logic [ID_W-1:0] rand_id();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [HASH_W-1:0] pick_hash();
        if ($urandom_range(0, 3) != 0)
            return hot_row[$urandom_range(0, HOT_ROWS - 1)];
        return HASH_W'($urandom_range(0, 65535));
    endfunction

    // Inserts fill empty tiles in hash order; reads queue one row word per hash.
    task automatic apply_to_tile_rows(logic op, logic [NUM_HASH-1:0][HASH_W-1:0] h,
                                      logic [ID_W-1:0] ida, logic [ID_W-1:0] idb);
        logic [CODE_W-1:0]         code;
        logic [TILE_ADDR_BITS-1:0] col;
        logic [TILE_BITS-1:0]      val;
        logic [ROW_W-1:0]          word;
        int                        shift;
        row_beat_t                 rb;
        if (op == OP_INSERT)
        begin
            for (int i = 0; i < NUM_HASH; i++)
            begin
                code = '0;
                for (int j = 0; j < NUM_HASH; j++)
                    if (j != i)
                        code = (code << 1) | CODE_W'(h[j][i]);
                col   = ida[code * TILE_ADDR_BITS +: TILE_ADDR_BITS];
                val   = idb[code * TILE_BITS +: TILE_BITS];
                shift = (TILES - 1 - col) * TILE_BITS;
                word  = tile_rows[h[i]];
                if (word[shift +: TILE_BITS] == '0)
                begin
                    word[shift +: TILE_BITS] = val;
                    tile_rows[h[i]] = word;
                end
            end
        end
        else
        begin
            for (int i = 0; i < NUM_HASH; i++)
            begin
                rb.idx  = IDX_W'(i);
                rb.word = tile_rows[h[i]];
                rb.last = (i == NUM_HASH - 1);
                row_words_due.insert(row_words_due.size(), rb);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_inputs
        tile_cmd_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_to_tile_rows(opcode, {hash_3, hash_2, hash_1, hash_0},
                                   id_hash_a, id_hash_b);
                beats_in <= beats_in + 1;
            end
            if (!(in_valid && !in_ready))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (cmd_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                begin
                    tx_gap   <= $urandom_range(0, 6);
                    in_valid <= 1'b0;
                end
                else if (cmd_q.size() != 0 &&
                         !(cmd_q[0].wait_drain && row_words_due.size() != 0))
                begin
                    nxt       = cmd_q.pop_front();
                    opcode    <= nxt.op;
                    hash_0    <= nxt.hashes[0];
                    hash_1    <= nxt.hashes[1];
                    hash_2    <= nxt.hashes[2];
                    hash_3    <= nxt.hashes[3];
                    id_hash_a <= nxt.ida;
                    id_hash_b <= nxt.idb;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && beats_in >= HOLD_AT_BEAT)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap    <= rx_gap - 1;
            out_ready <= 1'b0;
        end
        else if (cmd_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
        begin
            rx_gap    <= $urandom_range(0, 6);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_outputs
        row_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (row_words_due.size() == 0)
            begin
                report_mismatch("row word with none pending", row_word, '0);
            end
            else
            begin
                want = row_words_due.pop_front();
                if (hash_index !== want.idx)
                    report_mismatch("hash_index", ROW_W'(hash_index), ROW_W'(want.idx));
                if (row_word !== want.word)
                    report_mismatch("row_word", row_word, want.word);
                if (last !== want.last)
                    report_mismatch("last", ROW_W'(last), ROW_W'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("hashed_tile_table_insert_read_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        hot_row[0] = 16'h0000;
        hot_row[1] = 16'hFFFF;
        for (int k = 2; k < HOT_ROWS; k++)
            hot_row[k] = HASH_W'($urandom_range(0, 65535));

        // Untouched rows read back as zero.
        push_cmd(OP_READ, 16'h0000, 16'hFFFF, 16'h1234, 16'h8000, '0, '0, 1'b0);
        // Every hash lands on the same row, so only the first write sticks.
        push_cmd(OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '1, '1, 1'b0);
        push_cmd(OP_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '0, '0, 1'b0);
        push_cmd(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0, rand_id(), 1'b0);
        push_cmd(OP_READ, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, '0, '0, 1'b1);
        // A zero value leaves the tile empty and open to a later insert.
        push_cmd(OP_INSERT, 16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0, rand_id(), '0, 1'b0);
        push_cmd(OP_READ, 16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0, '0, '0, 1'b0);
        push_cmd(OP_INSERT, 16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0, rand_id(), '1, 1'b0);
        push_cmd(OP_READ, 16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0, '0, '0, 1'b0);
        push_cmd(OP_INSERT, 16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF, rand_id(), rand_id(), 1'b0);
        push_cmd(OP_INSERT, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, '1, rand_id(), 1'b0);
        push_cmd(OP_INSERT, 16'h7777, 16'h8888, 16'h7777, 16'h8888, rand_id(), rand_id(), 1'b0);
        push_cmd(OP_INSERT, 16'h7777, 16'h7777, 16'h8888, 16'h7777, rand_id(), rand_id(), 1'b0);
        push_cmd(OP_READ, 16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF, '1, '1, 1'b0);
        push_cmd(OP_READ, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, '0, '0, 1'b0);
        push_cmd(OP_READ, 16'h7777, 16'h8888, 16'h7777, 16'h8888, rand_id(), rand_id(), 1'b0);
        push_cmd(OP_INSERT, 16'h0001, 16'h8000, 16'h7FFE, 16'hFFFF, '1, 64'h8000_0000_0000_0001,
                 1'b0);
        push_cmd(OP_READ, 16'h0001, 16'h8000, 16'h7FFE, 16'hFFFF, '0, '0, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            push_cmd($urandom_range(0, 1) ? OP_READ : OP_INSERT,
                     pick_hash(), pick_hash(), pick_hash(), pick_hash(),
                     rand_id(), rand_id(), n == RANDOM_ITEMS / 2);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() != 0 || in_valid || row_words_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (error_count == 0)
            $display("hashed_tile_table_insert_read_tb OK");
        else
            $display("hashed_tile_table_insert_read_tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/htt_pkg.sv
rtl/core/htt_datapath.sv
rtl/core/htt_ctrl.sv
rtl/core/hashed_tile_table_insert_read.sv
verif/hashed_tile_table_insert_read_tb.sv
